/* sv/uvic_pkg.sv */
// Shared types, action codes and sizing constants for the vertex index compaction core.
`timescale 1ns / 1ps
`default_nettype none

package uvic_pkg;

   // Number of old point ids the bitmap and tables cover.
   localparam int MAX_POINTS = 65536;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   localparam int ACTION_W   = 3;
   localparam int ID_W       = 16;
   localparam int VALUE_W    = 17;

   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_MARK     = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FINALIZE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REMAP    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_INVERSE  = 3'd4;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ID_W-1:0]     point_id;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               valid_res;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/unused_vertex_index_compaction_core.sv */
// Top level of the vertex index compaction core: bitmap, remap tables and their sequencer.
// Mark and unknown actions answer directly: the result beat is registered at the accept edge.
// Remap and inverse read the registered memories at the accept edge and answer from the
// read data in the lookup state; one that the tables cannot answer (stale tables or an
// index beyond the count) is answered at the accept edge. Clear and finalize each sweep
// the bitmap one entry per cycle. One item is in flight at a time.
// After reset the bitmap is swept clear over all MAX_POINTS entries, req_ready held low.
`timescale 1ns / 1ps
`default_nettype none

module unused_vertex_index_compaction_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire uvic_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output uvic_pkg::rsp_type      rsp_data
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CLEAR  = 2'd1;
   localparam logic [1:0] ST_FIN    = 2'd2;
   localparam logic [1:0] ST_LOOKUP = 2'd3;

   // The three memories. The bitmap is cleared by a sweep; table data is only ever used
   // from entries that the last finalize wrote, so the tables need no clearing.
   logic                      used_mem   [uvic_pkg::MAX_POINTS];
   logic [uvic_pkg::ID_W-1:0] new_idx_mem[uvic_pkg::MAX_POINTS];
   logic [uvic_pkg::ID_W-1:0] old_id_mem [uvic_pkg::MAX_POINTS];

   // Registered read data of the memories.
   logic                      used_rd_ff;
   logic [uvic_pkg::ID_W-1:0] new_rd_ff;
   logic [uvic_pkg::ID_W-1:0] old_rd_ff;

   // Memory port controls.
   logic                       map_we, map_wdata, map_re;
   logic [uvic_pkg::IDX_W-1:0] map_waddr, map_raddr;
   logic                       new_we, new_re;
   logic [uvic_pkg::IDX_W-1:0] new_waddr, new_raddr;
   logic [uvic_pkg::ID_W-1:0]  new_wdata;
   logic                       old_we, old_re;
   logic [uvic_pkg::IDX_W-1:0] old_waddr, old_raddr;
   logic [uvic_pkg::ID_W-1:0]  old_wdata;

   // Control and payload registers.
   logic [1:0]                   state_ff, state_in;
   logic [uvic_pkg::CNT_W-1:0]   addr_ff, addr_in;
   logic [uvic_pkg::CNT_W-1:0]   next_ff, next_in;
   logic                         walk_vld_ff, walk_vld_in;
   logic [uvic_pkg::IDX_W-1:0]   walk_id_ff, walk_id_in;
   logic                         remap_op_ff, remap_op_in;
   logic                         clr_rsp_ff, clr_rsp_in;
   logic [uvic_pkg::VALUE_W-1:0] used_count_ff, used_count_in;
   logic                         tables_ready_ff, tables_ready_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   uvic_pkg::rsp_type            rsp_ff, rsp_in;

   logic accept;
   logic rsp_load;
   logic pid_in_range;

   // A new beat is taken only when idle and the result register is free or being
   // emptied in this cycle, so every later result finds the register free.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pid_in_range = 32'(req_data.point_id) < uvic_pkg::MAX_POINTS;

   always_comb begin
      state_in        = state_ff;
      addr_in         = addr_ff;
      next_in         = next_ff;
      walk_vld_in     = 1'b0;
      walk_id_in      = walk_id_ff;
      remap_op_in     = remap_op_ff;
      clr_rsp_in      = clr_rsp_ff;
      used_count_in   = used_count_ff;
      tables_ready_in = tables_ready_ff;
      rsp_load        = 1'b0;
      rsp_in          = rsp_ff;

      map_we    = 1'b0;
      map_waddr = '0;
      map_wdata = 1'b0;
      map_re    = 1'b0;
      map_raddr = uvic_pkg::IDX_W'(req_data.point_id);
      new_we    = 1'b0;
      new_waddr = walk_id_ff;
      new_wdata = uvic_pkg::ID_W'(next_ff);
      new_re    = 1'b0;
      new_raddr = uvic_pkg::IDX_W'(req_data.point_id);
      old_we    = 1'b0;
      old_waddr = next_ff[uvic_pkg::IDX_W-1:0];
      old_wdata = uvic_pkg::ID_W'(walk_id_ff);
      old_re    = 1'b0;
      old_raddr = uvic_pkg::IDX_W'(req_data.point_id);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  uvic_pkg::ACT_CLEAR: begin
                     // The count and ready flag drop at once; the bitmap is swept.
                     used_count_in   = '0;
                     tables_ready_in = 1'b0;
                     addr_in         = '0;
                     clr_rsp_in      = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  uvic_pkg::ACT_MARK: begin
                     rsp_load       = 1'b1;
                     rsp_in.value   = '0;
                     rsp_in.valid_res = pid_in_range;
                     if (pid_in_range) begin
                        map_we          = 1'b1;
                        map_waddr       = uvic_pkg::IDX_W'(req_data.point_id);
                        map_wdata       = 1'b1;
                        tables_ready_in = 1'b0;
                     end
                  end
                  uvic_pkg::ACT_FINALIZE: begin
                     addr_in  = '0;
                     next_in  = '0;
                     state_in = ST_FIN;
                  end
                  uvic_pkg::ACT_REMAP: begin
                     if (tables_ready_ff && pid_in_range) begin
                        map_re      = 1'b1;
                        new_re      = 1'b1;
                        remap_op_in = 1'b1;
                        state_in    = ST_LOOKUP;
                     end else begin
                        rsp_load = 1'b1;
                        rsp_in   = '0;
                     end
                  end
                  uvic_pkg::ACT_INVERSE: begin
                     if (tables_ready_ff && pid_in_range &&
                         (32'(req_data.point_id) < 32'(used_count_ff))) begin
                        old_re      = 1'b1;
                        remap_op_in = 1'b0;
                        state_in    = ST_LOOKUP;
                     end else begin
                        rsp_load = 1'b1;
                        rsp_in   = '0;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                     rsp_in   = '0;
                  end
               endcase
            end
         end

         ST_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = addr_ff[uvic_pkg::IDX_W-1:0];
            map_wdata = 1'b0;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == uvic_pkg::CNT_W'(uvic_pkg::MAX_POINTS - 1)) begin
               state_in   = ST_IDLE;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_load         = 1'b1;
                  rsp_in.value     = '0;
                  rsp_in.valid_res = 1'b1;
               end
            end
         end

         ST_FIN: begin
            // Read stage: one bitmap entry per cycle in ascending order.
            if (addr_ff != uvic_pkg::CNT_W'(uvic_pkg::MAX_POINTS)) begin
               map_re      = 1'b1;
               map_raddr   = addr_ff[uvic_pkg::IDX_W-1:0];
               walk_vld_in = 1'b1;
               walk_id_in  = addr_ff[uvic_pkg::IDX_W-1:0];
               addr_in     = addr_ff + 1'b1;
            end
            // Write stage: a used id gets the next dense index in both tables.
            if (walk_vld_ff && used_rd_ff) begin
               new_we  = 1'b1;
               old_we  = 32'(next_ff) < uvic_pkg::MAX_POINTS;
               next_in = next_ff + 1'b1;
            end
            if ((addr_ff == uvic_pkg::CNT_W'(uvic_pkg::MAX_POINTS)) && !walk_vld_ff) begin
               used_count_in    = uvic_pkg::VALUE_W'(next_ff);
               tables_ready_in  = 1'b1;
               rsp_load         = 1'b1;
               rsp_in.value     = uvic_pkg::VALUE_W'(next_ff);
               rsp_in.valid_res = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         ST_LOOKUP: begin
            rsp_load = 1'b1;
            state_in = ST_IDLE;
            if (remap_op_ff) begin
               rsp_in.value     = used_rd_ff ? uvic_pkg::VALUE_W'(new_rd_ff) : '0;
               rsp_in.valid_res = used_rd_ff;
            end else begin
               rsp_in.value     = uvic_pkg::VALUE_W'(old_rd_ff);
               rsp_in.valid_res = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers. Reset starts the clearing pass over the bitmap.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         addr_ff         <= '0;
         walk_vld_ff     <= 1'b0;
         clr_rsp_ff      <= 1'b0;
         used_count_ff   <= '0;
         tables_ready_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         addr_ff         <= addr_in;
         walk_vld_ff     <= walk_vld_in;
         clr_rsp_ff      <= clr_rsp_in;
         used_count_ff   <= used_count_in;
         tables_ready_ff <= tables_ready_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      next_ff     <= next_in;
      walk_id_ff  <= walk_id_in;
      remap_op_ff <= remap_op_in;
      rsp_ff      <= rsp_in;
   end

   // Used-point bitmap.
   always_ff @(posedge clock) begin
      if (map_we) begin
         used_mem[map_waddr] <= map_wdata;
      end
      if (map_re) begin
         used_rd_ff <= used_mem[map_raddr];
      end
   end

   // Forward table: old id to new index.
   always_ff @(posedge clock) begin
      if (new_we) begin
         new_idx_mem[new_waddr] <= new_wdata;
      end
      if (new_re) begin
         new_rd_ff <= new_idx_mem[new_raddr];
      end
   end

   // Inverse table: new index to old id.
   always_ff @(posedge clock) begin
      if (old_we) begin
         old_id_mem[old_waddr] <= old_wdata;
      end
      if (old_re) begin
         old_rd_ff <= old_id_mem[old_raddr];
      end
   end

endmodule

`default_nettype wire

/* sv/uvic_checker.sv */
// Port-level checker for the vertex index compaction core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module uvic_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_ready,
   input wire uvic_pkg::req_type req_data,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire uvic_pkg::rsp_type rsp_data
);

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Reset starts the bitmap clearing pass, which refuses input.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input taken during the clearing pass after reset");

   // A clear beat starts a sweep, so the next cycle refuses input.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.action == uvic_pkg::ACT_CLEAR) |=> !req_ready)
      else $error("input taken during a clear sweep");

   // An unknown action answers at once with an invalid, zero result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      !(req_data.action == uvic_pkg::ACT_CLEAR || req_data.action == uvic_pkg::ACT_MARK ||
        req_data.action == uvic_pkg::ACT_FINALIZE || req_data.action == uvic_pkg::ACT_REMAP ||
        req_data.action == uvic_pkg::ACT_INVERSE)
      |=> rsp_valid && !rsp_data.valid_res && (rsp_data.value == '0))
      else $error("unknown action not answered with an invalid result");

   // An invalid result always carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data.value == '0)
      else $error("invalid result with a non-zero value");

endmodule

bind unused_vertex_index_compaction_core uvic_checker u_uvic_checker (.*);

`default_nettype wire
